FILE: rtl/itoa_pkg.sv
// shared types and constants for the signed integer to decimal text block
package itoa_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// magnitude bits folded into the bcd register per conversion cycle
	localparam int DABBLE_BITS = 4;

	typedef struct packed {
		logic load;
		logic step;
		logic find;
		logic emit_sign;
		logic emit_digit;
	} dp_cmd_t;

	typedef struct packed {
		logic conv_done;
		logic neg;
		logic last_digit;
	} dp_sts_t;

endpackage

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// top level: signed integer to decimal ascii text converter
//
//  channel  direction  handshake            payload
//  input    in         start / busy         value
//  result   out        char_strobe (1 cyc)  text_char, is_last
//
// an item is taken when start is high and busy is low. the magnitude is
// converted to bcd by shift-add-3, four bits per cycle. the leading digit is
// then found, and one character per cycle leaves: a sign if negative, then
// the digits, msd first. each character sits in the output register for
// exactly one cycle; the receiver cannot stall. the last character shows in
// the cycle busy drops, so the next item may be taken at that edge. reset
// clears the controller, the step counter and the strobe only.
module signed_int_to_decimal_ascii_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          char_strobe,
	output logic [7:0]                    text_char,
	output logic                          is_last
);
	import itoa_pkg::*;

	// command and status between controller and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	itoa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	itoa_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.char_strobe (char_strobe),
		.text_char   (text_char),
		.is_last     (is_last)
	);

	// a character that is not the last is always followed by another
	a_text_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe && !is_last |=> char_strobe)
		else $error("gap inside an item's text");

	// the final character shows only once the controller is free again
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe && is_last |-> !busy)
		else $error("last character while still busy");

	// a fresh item never starts with a character already on the way
	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !char_strobe)
		else $error("accepted item did not start cleanly");

	// a minus sign is never the last character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe && (text_char == CHAR_MINUS) |-> !is_last)
		else $error("minus sign marked last");

endmodule

FILE: rtl/itoa_dp.sv
// datapath: magnitude, shift-add-3 bcd conversion, digit select and output register
module itoa_dp #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  itoa_pkg::dp_cmd_t             cmd,
	output itoa_pkg::dp_sts_t             sts,
	output logic                          char_strobe,
	output logic [7:0]                    text_char,
	output logic                          is_last
);
	import itoa_pkg::*;

	// decimal digits of 2^(VALUE_WIDTH-1)
	localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int BCD_W = NDIG * 4;
	localparam int NSTEP = (VALUE_WIDTH + DABBLE_BITS - 1) / DABBLE_BITS;
	localparam int SH_W  = NSTEP * DABBLE_BITS;
	localparam int CNT_W = $clog2(NSTEP + 1);
	localparam int IDX_W = $clog2(NDIG);

	logic [SH_W-1:0]        sh_q, sh_n;
	logic [BCD_W-1:0]       bcd_q, bcd_n;
	logic [CNT_W-1:0]       step_cnt_q;
	logic [IDX_W-1:0]       digit_idx_q, top_idx;
	logic                   neg_q;
	logic [VALUE_WIDTH-1:0] value_u, mag;
	logic                   strobe_q, is_last_q;
	logic [7:0]             char_q;

	assign value_u = value;
	assign mag = value_u[VALUE_WIDTH-1]
		? (~value_u + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_u;

	// DABBLE_BITS shift-add-3 steps per cycle, digits adjusted in parallel
	always_comb begin
		bcd_n = bcd_q;
		sh_n  = sh_q;
		for (int b = 0; b < DABBLE_BITS; b++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_n[d*4 +: 4] >= 4'd5)
					bcd_n[d*4 +: 4] = bcd_n[d*4 +: 4] + 4'd3;
			end
			bcd_n = {bcd_n[BCD_W-2:0], sh_n[SH_W-1]};
			sh_n  = {sh_n[SH_W-2:0], 1'b0};
		end
	end

	// highest nonzero digit, zero when the value is zero
	always_comb begin
		top_idx = '0;
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0)
				top_idx = IDX_W'(d);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q  <= SH_W'(mag);
			bcd_q <= '0;
			neg_q <= value_u[VALUE_WIDTH-1];
		end else if (cmd.step) begin
			sh_q  <= sh_n;
			bcd_q <= bcd_n;
		end
		if (cmd.find)
			digit_idx_q <= top_idx;
		else if (cmd.emit_digit)
			digit_idx_q <= digit_idx_q - 1'b1;
		if (cmd.emit_sign) begin
			char_q    <= CHAR_MINUS;
			is_last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q    <= CHAR_ZERO + {4'd0, bcd_q[digit_idx_q*4 +: 4]};
			is_last_q <= (digit_idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cnt_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			if (cmd.load)
				step_cnt_q <= '0;
			else if (cmd.step)
				step_cnt_q <= step_cnt_q + 1'b1;
			strobe_q <= cmd.emit_sign | cmd.emit_digit;
		end
	end

	assign sts.conv_done  = (step_cnt_q == CNT_W'(NSTEP - 1));
	assign sts.neg        = neg_q;
	assign sts.last_digit = (digit_idx_q == '0);

	assign char_strobe = strobe_q;
	assign text_char   = char_q;
	assign is_last     = is_last_q;

endmodule

FILE: rtl/itoa_ctrl.sv
// controller: sequences load, conversion, digit search and character output
module itoa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  itoa_pkg::dp_sts_t sts,
	output itoa_pkg::dp_cmd_t cmd,
	output logic              busy
);
	import itoa_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_FIND  = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_DIGIT = 3'd4;

	logic [2:0] state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_n  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				if (sts.conv_done)
					state_n = ST_FIND;
			end
			ST_FIND: begin
				cmd.find = 1'b1;
				state_n  = sts.neg ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				cmd.emit_sign = 1'b1;
				state_n       = ST_DIGIT;
			end
			ST_DIGIT: begin
				cmd.emit_digit = 1'b1;
				if (sts.last_digit)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	assign busy = (state_q != ST_IDLE);

endmodule
